/* rtl/core/sorted_priority_queue_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the sorted priority queue RTL
// Every macro samples on clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// condition that holds on every clock edge
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// temporal property
`define SPQ_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* rtl/core/spq_pkg.sv */
// ---------------------------------------------------------------------------
// spq_pkg
// Shared constants, operation codes and control types of the sorted
// priority queue.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int PRIO_BITS_DEF = 16;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_ENQ = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEQ = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEQ_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ENQ_FULL  = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;   // latch the accepted transaction
    logic execute;   // update the store and load the result register
  } spq_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/spq_if.sv */
// ---------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels carrying queue requests and queue results.
// ---------------------------------------------------------------------------
`default_nettype none

interface spq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] value;
  logic [15:0]        priority_req;

  modport source (output valid, action, value, priority_req, input ready);
  modport sink   (input valid, action, value, priority_req, output ready);
endinterface

interface spq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data;
  logic [1:0]         status;
  logic [4:0]         count;
  logic               empty_res;

  modport source (output valid, data, status, count, empty_res, input ready);
  modport sink   (input valid, data, status, count, empty_res, output ready);
endinterface

`default_nettype wire

/* rtl/core/spq_datapath.sv */
// ---------------------------------------------------------------------------
// spq_datapath
// Sorted cell chain, element count, request latch and result register.
// All cells compare against the new priority at once and shift together.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_datapath #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire spq_pkg::spq_cmd_t   cmd,
  input  wire logic [1:0]          in_action,
  input  wire logic signed [31:0]  in_value,
  input  wire logic [15:0]         in_priority_req,
  output logic signed [31:0]       res_data,
  output logic [1:0]               res_status,
  output logic [4:0]               res_count,
  output logic                     res_empty
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [ACTION_W-1:0]  op_action_r;
  logic [VALUE_W-1:0]   op_value_r;
  logic [PRIO_BITS-1:0] op_prio_r;

  logic [VALUE_W-1:0]   val_r   [DEPTH];
  logic [PRIO_BITS-1:0] pri_r   [DEPTH];
  logic [VALUE_W-1:0]   val_nxt [DEPTH];
  logic [PRIO_BITS-1:0] pri_nxt [DEPTH];
  logic [CW-1:0]        cnt_r, cnt_nxt;

  logic [VALUE_W-1:0]   res_data_r, res_data_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [CW-1:0]        res_cnt_r;
  logic                 res_empty_r;

  logic [DEPTH-1:0]     le;      // occupied cell whose priority <= new one
  logic                 full, empty;
  logic [PRIO_BITS+PRIO_W-1:0] prio_ext;
  logic [CW+COUNT_W-1:0]       cnt_ext;

  // priority taken modulo 2^PRIO_BITS
  assign prio_ext = {{PRIO_BITS{1'b0}}, in_priority_req};

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CW'(i) < cnt_r) && (pri_r[i] <= op_prio_r);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
    end
    cnt_nxt        = cnt_r;
    res_status_nxt = ST_OK;
    res_data_nxt   = empty ? '0 : val_r[0];

    unique case (op_action_r)
      ACT_ENQ: begin
        if (full) begin
          res_status_nxt = ST_ENQ_FULL;
        end else begin
          // keep cells ahead, drop new entry in the first slot behind them,
          // shift the rest down by one
          for (int i = 0; i < DEPTH; i++) begin
            if (!le[i]) begin
              if (i == 0) begin
                val_nxt[i] = op_value_r;
                pri_nxt[i] = op_prio_r;
              end else if (le[i-1]) begin
                val_nxt[i] = op_value_r;
                pri_nxt[i] = op_prio_r;
              end else begin
                val_nxt[i] = val_r[i-1];
                pri_nxt[i] = pri_r[i-1];
              end
            end
          end
          cnt_nxt      = cnt_r + 1'b1;
          res_data_nxt = (empty || !le[0]) ? op_value_r : val_r[0];
        end
      end
      ACT_DEQ: begin
        if (empty) begin
          res_status_nxt = ST_DEQ_EMPTY;
          res_data_nxt   = '0;
        end else begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            val_nxt[i] = val_r[i+1];
            pri_nxt[i] = pri_r[i+1];
          end
          cnt_nxt      = cnt_r - 1'b1;
          res_data_nxt = val_r[0];
        end
      end
      ACT_CLR: begin
        cnt_nxt      = '0;
        res_data_nxt = '0;
      end
      default: begin
        // unused code: report head only
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.execute) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_action_r <= in_action;
      op_value_r  <= in_value;
      op_prio_r   <= prio_ext[PRIO_BITS-1:0];
    end
    if (cmd.execute) begin
      for (int i = 0; i < DEPTH; i++) begin
        val_r[i] <= val_nxt[i];
        pri_r[i] <= pri_nxt[i];
      end
      res_data_r   <= res_data_nxt;
      res_status_r <= res_status_nxt;
      res_cnt_r    <= cnt_nxt;
      res_empty_r  <= (cnt_nxt == '0);
    end
  end

  assign cnt_ext    = {{COUNT_W{1'b0}}, res_cnt_r};
  assign res_data   = res_data_r;
  assign res_status = res_status_r;
  assign res_count  = cnt_ext[COUNT_W-1:0];
  assign res_empty  = res_empty_r;

`include "sorted_priority_queue_unit_defines.svh"

  `SPQ_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(DEPTH), "count exceeds depth")
  `SPQ_ASSERT_PROP(a_clr_empties,
                   (cmd.execute && op_action_r == ACT_CLR) |=> (cnt_r == '0),
                   "clear left entries")
  `SPQ_ASSERT_PROP(a_full_drop,
                   (cmd.execute && op_action_r == ACT_ENQ && full) |=> $stable(cnt_r),
                   "enqueue on full changed count")
  `SPQ_ASSERT_PROP(a_deq_dec,
                   (cmd.execute && op_action_r == ACT_DEQ && !empty)
                     |=> (cnt_r == CW'($past(cnt_r) - 1'b1)),
                   "dequeue did not drop one entry")

endmodule

`default_nettype wire

/* rtl/core/spq_ctrl.sv */
// ---------------------------------------------------------------------------
// spq_ctrl
// Two-state sequencer: take a transaction, then execute it once the result
// register is free or being drained. Owns the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output spq_pkg::spq_cmd_t       cmd
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free   = !out_valid_r || out_ready;
  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state_r == S_EXEC) && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (cmd.capture) state_nxt = S_EXEC;
      S_EXEC:  if (cmd.execute) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/sorted_priority_queue_unit.sv */
// ---------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded min-first priority queue kept as a sorted chain of cells.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per transaction: action (enqueue, dequeue,
//   clear), value and priority_req. out_ch returns exactly one result per
//   request: data, status, count and empty_res, in request order.
//   Equal priorities leave in arrival order. An enqueue on a full queue is
//   dropped with status "full"; a dequeue on an empty queue returns 0 with
//   status "empty".
//   An accepted request waits in the request latch and is executed into
//   the result register once that register is free. A new request is taken
//   only after the last one has executed: the request latch and the
//   compare-and-shift of all cells form a two-step sequence for each request.
//   The result register holds while out_ch.ready is low; the next request
//   is still taken and waits in the request latch until the result leaves.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; cell contents are left as they are.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_action       (in_ch.action),
    .in_value        (in_ch.value),
    .in_priority_req (in_ch.priority_req),
    .res_data        (out_ch.data),
    .res_status      (out_ch.status),
    .res_count       (out_ch.count),
    .res_empty       (out_ch.empty_res)
  );

endmodule

`default_nettype wire
